>>> rtl/mdpc_pkg.sv
// shared types, constants and helper functions for the display pointer clamp
// no dependencies
`default_nettype none

package mdpc_pkg;

  localparam int MAX_DISPLAYS = 4;
  localparam int CNT_W = $clog2(MAX_DISPLAYS + 1);
  localparam int IDX_W = (MAX_DISPLAYS > 1) ? $clog2(MAX_DISPLAYS) : 1;

  localparam logic [14:0] DEF_W = 15'd1280;
  localparam logic [14:0] DEF_H = 15'd720;

  localparam logic [1:0] ACT_INIT   = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_CLAMP  = 2'd2;
  localparam logic [1:0] ACT_UPDATE = 2'd3;

  typedef struct packed {
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [14:0]        w;
    logic [14:0]        h;
  } disp_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    disp_t            entry;
  } tbl_wr_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v < -18'sd32768) begin
      r = -16'sd32768;
    end else if (v > 18'sd32767) begin
      r = 16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [17:0] max_edge(input logic signed [15:0] o,
                                                  input logic [14:0] s);
    return 18'(o) + $signed({3'b000, s}) - 18'sd1;
  endfunction

  function automatic logic point_in(input disp_t d, input logic signed [15:0] px,
                                    input logic signed [15:0] py);
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic               in_x;
    logic               in_y;
    dx = 17'(px) - 17'(d.ox);
    dy = 17'(py) - 17'(d.oy);
    in_x = (dx >= 17'sd0) && (dx < $signed({2'b00, d.w}));
    in_y = (dy >= 17'sd0) && (dy < $signed({2'b00, d.h}));
    return in_x && in_y;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mdpc_in_if.sv
// request channel: action, point or origin and size
// depends on nothing
`default_nettype none

interface mdpc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [14:0]        size_w;
  logic [14:0]        size_h;

  modport source (output valid, action, pos_x, pos_y, size_w, size_h, input ready);
  modport sink (input valid, action, pos_x, pos_y, size_w, size_h, output ready);
endinterface

`default_nettype wire

>>> rtl/mdpc_out_if.sv
// result channel: output point, flags and primary display corner
// depends on nothing
`default_nettype none

interface mdpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic               inside_any;
  logic               add_accepted;
  logic signed [15:0] primary_max_x;
  logic signed [15:0] primary_max_y;

  modport source (output valid, out_x, out_y, inside_any, add_accepted,
                  primary_max_x, primary_max_y, input ready);
  modport sink (input valid, out_x, out_y, inside_any, add_accepted,
                primary_max_x, primary_max_y, output ready);
endinterface

`default_nettype wire

>>> rtl/multi_display_pointer_clamp_top.sv
// top level: action sequencer, display table scan and output register
// depends on mdpc_pkg, mdpc_in_if, mdpc_out_if, mdpc_table, mdpc_result
//
//   channel | dir | payload
//   req     | in  | action, pos_x, pos_y, size_w, size_h
//   rsp     | out | out_x, out_y, inside_any, add_accepted, primary_max_x/y
//
// init, add, update: result state, then output register once that is free
// clamp: n displays scanned until the first hit (1..4), then the result state;
//   one table read per cycle through the single memory read port
// synchronous reset empties the table (count 0); no clearing pass
// a finished result waits in the output register while the next request is taken
`default_nettype none

module multi_display_pointer_clamp_top (
  input wire logic   clk,
  input wire logic   rst,
  mdpc_in_if.sink    req,
  mdpc_out_if.source rsp
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0]                 state;
  logic [1:0]                 state_next;
  logic [mdpc_pkg::CNT_W-1:0] count;
  logic [mdpc_pkg::CNT_W-1:0] count_next;
  logic [mdpc_pkg::IDX_W-1:0] chk;
  logic [mdpc_pkg::IDX_W-1:0] chk_next;
  logic [1:0]                 act;
  logic signed [15:0]         px;
  logic signed [15:0]         py;
  logic                       found;
  logic                       found_next;
  logic                       acc;
  logic                       acc_next;
  mdpc_pkg::disp_t            prim;
  mdpc_pkg::disp_t            prim_next;

  mdpc_pkg::tbl_wr_t          wr;
  logic [mdpc_pkg::IDX_W-1:0] rd_addr;
  mdpc_pkg::disp_t            rd_data;
  mdpc_pkg::disp_t            init_ent;
  mdpc_pkg::disp_t            new_ent;

  logic                       accept;
  logic                       hit;
  logic                       last;
  logic                       out_load;
  logic signed [15:0]         res_x;
  logic signed [15:0]         res_y;
  logic signed [15:0]         max_x;
  logic signed [15:0]         max_y;

  mdpc_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mdpc_result u_result (
    .act    (act),
    .px     (px),
    .py     (py),
    .found  (found),
    .have   (count != '0),
    .prim   (prim),
    .res_x  (res_x),
    .res_y  (res_y),
    .max_x  (max_x),
    .max_y  (max_y)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign hit       = mdpc_pkg::point_in(rd_data, px, py);
  assign last      = (mdpc_pkg::CNT_W'(chk) + mdpc_pkg::CNT_W'(1)) == count;
  assign out_load  = (state == S_RESULT) && (!rsp.valid || rsp.ready);

  always_comb begin
    init_ent.ox = 16'sd0;
    init_ent.oy = 16'sd0;
    init_ent.w  = (req.size_w == '0) ? mdpc_pkg::DEF_W : req.size_w;
    init_ent.h  = (req.size_h == '0) ? mdpc_pkg::DEF_H : req.size_h;
    new_ent.ox  = req.pos_x;
    new_ent.oy  = req.pos_y;
    new_ent.w   = req.size_w;
    new_ent.h   = req.size_h;

    state_next  = state;
    count_next  = count;
    chk_next    = chk;
    found_next  = found;
    acc_next    = acc;
    prim_next   = prim;
    wr.en       = 1'b0;
    wr.addr     = '0;
    wr.entry    = init_ent;
    rd_addr     = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          found_next  = 1'b0;
          acc_next    = 1'b0;
          chk_next    = '0;
          state_next  = S_RESULT;
          case (req.action)
            mdpc_pkg::ACT_INIT: begin
              wr.en      = 1'b1;
              prim_next  = init_ent;
              count_next = mdpc_pkg::CNT_W'(1);
            end
            mdpc_pkg::ACT_ADD: begin
              if ((count < mdpc_pkg::CNT_W'(mdpc_pkg::MAX_DISPLAYS)) &&
                  (req.size_w != '0) && (req.size_h != '0)) begin
                wr.en      = 1'b1;
                wr.addr    = count[mdpc_pkg::IDX_W-1:0];
                wr.entry   = new_ent;
                count_next = count + mdpc_pkg::CNT_W'(1);
                acc_next   = 1'b1;
                if (count == '0) begin
                  prim_next = new_ent;
                end
              end
            end
            mdpc_pkg::ACT_UPDATE: begin
              wr.en = 1'b1;
              if (count != '0) begin
                wr.entry    = prim;
                wr.entry.w  = req.size_w;
                wr.entry.h  = req.size_h;
                prim_next.w = req.size_w;
                prim_next.h = req.size_h;
              end else begin
                prim_next  = init_ent;
                count_next = mdpc_pkg::CNT_W'(1);
              end
            end
            mdpc_pkg::ACT_CLAMP: begin
              if (count != '0) begin
                state_next = S_SCAN;
              end
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          found_next = 1'b1;
          state_next = S_RESULT;
        end else if (last) begin
          state_next = S_RESULT;
        end else begin
          chk_next = chk + mdpc_pkg::IDX_W'(1);
          rd_addr  = chk + mdpc_pkg::IDX_W'(1);
        end
      end
      S_RESULT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    chk   <= chk_next;
    found <= found_next;
    acc   <= acc_next;
    prim  <= prim_next;
    if (accept) begin
      act <= req.action;
      px  <= req.pos_x;
      py  <= req.pos_y;
    end
    if (out_load) begin
      rsp.out_x         <= res_x;
      rsp.out_y         <= res_y;
      rsp.inside_any    <= found;
      rsp.add_accepted  <= acc;
      rsp.primary_max_x <= max_x;
      rsp.primary_max_y <= max_y;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= mdpc_pkg::CNT_W'(mdpc_pkg::MAX_DISPLAYS))
    else $error("display count above table depth");

  a_scan_needs_displays: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (count != '0))
    else $error("table scan with no displays stored");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.inside_any && rsp.add_accepted))
    else $error("inside and add flags both set");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer idle right after a transaction");

endmodule

`default_nettype wire

>>> rtl/mdpc_table.sv
// display rectangle table: one write port, one registered read port
// depends on mdpc_pkg
`default_nettype none

module mdpc_table (
  input  wire logic                      clk,
  input  wire mdpc_pkg::tbl_wr_t         wr,
  input  wire logic [mdpc_pkg::IDX_W-1:0] rd_addr,
  output mdpc_pkg::disp_t                rd_data
);

  mdpc_pkg::disp_t mem [mdpc_pkg::MAX_DISPLAYS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/mdpc_result.sv
// result formation: clamp to the primary display, saturation, primary corner
// depends on mdpc_pkg
`default_nettype none

module mdpc_result (
  input  wire logic [1:0]         act,
  input  wire logic signed [15:0] px,
  input  wire logic signed [15:0] py,
  input  wire logic               found,
  input  wire logic               have,
  input  wire mdpc_pkg::disp_t    prim,
  output logic signed [15:0]      res_x,
  output logic signed [15:0]      res_y,
  output logic signed [15:0]      max_x,
  output logic signed [15:0]      max_y
);

  logic signed [17:0] x1;
  logic signed [17:0] y1;
  logic signed [15:0] lo_x;
  logic signed [15:0] lo_y;
  logic               do_clamp;

  always_comb begin
    x1 = mdpc_pkg::max_edge(prim.ox, prim.w);
    y1 = mdpc_pkg::max_edge(prim.oy, prim.h);
    do_clamp = (act == mdpc_pkg::ACT_CLAMP) && have && !found;
    lo_x = (px < prim.ox) ? prim.ox : px;
    lo_y = (py < prim.oy) ? prim.oy : py;
    res_x = px;
    res_y = py;
    if (do_clamp) begin
      res_x = (18'(lo_x) > x1) ? mdpc_pkg::sat16(x1) : lo_x;
      res_y = (18'(lo_y) > y1) ? mdpc_pkg::sat16(y1) : lo_y;
    end
    max_x = have ? mdpc_pkg::sat16(x1) : 16'sd0;
    max_y = have ? mdpc_pkg::sat16(y1) : 16'sd0;
  end

endmodule

`default_nettype wire
